// File: hw/rtl/dcss_pkg.sv
// Shared types and constants for the delayed command slot scheduler.
// Holds field widths, request codes, controller states and the
// controller/datapath command and status structs. No dependencies.
package dcss_pkg;

    localparam int DEF_SLOTS = 4;

    localparam int TYPE_W = 2;
    localparam int PAT_W  = 8;
    localparam int DUR_W  = 16;
    localparam int DLY_W  = 16;

    localparam logic [TYPE_W-1:0] REQ_TICK   = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_TIMED  = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_REPEAT = 2'd2;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic req_load;
        logic visit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic last_slot;
    } ctrl_status_t;

endpackage

// File: hw/rtl/delayed_command_slot_scheduler.sv
// Delayed command slot scheduler: top level joining controller and datapath.
// Play request: result (if any) strobed the cycle after transfer.
// Tick: busy while the slots are scanned, one slot visited per cycle; results are
// registered from the slot visits, at most one per cycle; the receiver cannot stall.
// Reset (rst_n low, asynchronous) frees all slots and clears the strobe.
module delayed_command_slot_scheduler
    import dcss_pkg::*;
#(
    parameter int SLOTS = DEF_SLOTS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [TYPE_W-1:0]        req_type,
    input  logic [PAT_W-1:0]         pattern,
    input  logic signed [DUR_W-1:0]  duration,
    input  logic [DLY_W-1:0]         delay,
    output logic                     valid,
    output logic                     cmd_kind,
    output logic [PAT_W-1:0]         pattern_index,
    output logic signed [DUR_W-1:0]  play_duration,
    output logic                     last
);

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    dcss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .status   (status),
        .busy     (busy),
        .cmd      (cmd)
    );

    dcss_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .req_type      (req_type),
        .pattern       (pattern),
        .duration      (duration),
        .delay         (delay),
        .valid         (valid),
        .cmd_kind      (cmd_kind),
        .pattern_index (pattern_index),
        .play_duration (play_duration),
        .last          (last)
    );

endmodule

// File: hw/rtl/dcss_ctrl.sv
// Controller for the delayed command slot scheduler.
// Decodes accepted items and sequences the slot scan on a tick.
// Depends on dcss_pkg.
module dcss_ctrl
    import dcss_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [TYPE_W-1:0]   req_type,
    input  ctrl_status_t        status,
    output logic                busy,
    output ctrl_cmd_t           cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        busy         = 1'b0;
        cmd.req_load = 1'b0;
        cmd.visit    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (req_type == REQ_TICK)
                    begin
                        state_next = ST_SCAN;
                    end
                    else if (req_type == REQ_TIMED || req_type == REQ_REPEAT)
                    begin
                        cmd.req_load = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                busy      = 1'b1;
                cmd.visit = 1'b1;
                if (status.last_slot)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/dcss_datapath.sv
// Datapath for the delayed command slot scheduler.
// Holds the slot store, the scan index and the result register.
// Depends on dcss_pkg; driven by dcss_ctrl commands.
module dcss_datapath
    import dcss_pkg::*;
#(
    parameter int SLOTS = DEF_SLOTS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  ctrl_cmd_t                cmd,
    output ctrl_status_t             status,
    input  logic [TYPE_W-1:0]        req_type,
    input  logic [PAT_W-1:0]         pattern,
    input  logic signed [DUR_W-1:0]  duration,
    input  logic [DLY_W-1:0]         delay,
    output logic                     valid,
    output logic                     cmd_kind,
    output logic [PAT_W-1:0]         pattern_index,
    output logic signed [DUR_W-1:0]  play_duration,
    output logic                     last
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [SLOTS-1:0]        busy_reg;
    logic [SLOTS-1:0]        busy_next;
    logic [DLY_W-1:0]        cnt_reg  [SLOTS];
    logic [DLY_W-1:0]        cnt_next [SLOTS];
    logic [PAT_W-1:0]        pat_reg  [SLOTS];
    logic [PAT_W-1:0]        pat_next [SLOTS];
    logic [DUR_W-1:0]        dur_reg  [SLOTS];
    logic [DUR_W-1:0]        dur_next [SLOTS];
    logic [SLOTS-1:0]        rep_reg;
    logic [SLOTS-1:0]        rep_next;
    logic [IDX_W-1:0]        idx_reg;
    logic [IDX_W-1:0]        idx_next;

    logic                    valid_reg;
    logic                    valid_next;
    logic                    kind_reg;
    logic                    kind_next;
    logic [PAT_W-1:0]        opat_reg;
    logic [PAT_W-1:0]        opat_next;
    logic [DUR_W-1:0]        odur_reg;
    logic [DUR_W-1:0]        odur_next;
    logic                    last_reg;
    logic                    last_next;

    logic                    free_found;
    logic [IDX_W-1:0]        free_idx;
    logic                    later_zero;
    logic                    emit_now;

    assign status.last_slot = (idx_reg == IDX_W'(SLOTS - 1));

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        later_zero = 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!free_found && !busy_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
            if (i > int'(idx_reg) && busy_reg[i] && cnt_reg[i] == '0)
            begin
                later_zero = 1'b1;
            end
        end
    end

    always_comb
    begin
        busy_next  = busy_reg;
        cnt_next   = cnt_reg;
        pat_next   = pat_reg;
        dur_next   = dur_reg;
        rep_next   = rep_reg;
        idx_next   = idx_reg;
        valid_next = 1'b0;
        kind_next  = kind_reg;
        opat_next  = opat_reg;
        odur_next  = odur_reg;
        last_next  = last_reg;
        emit_now   = 1'b0;

        if (cmd.req_load && pattern != '0)
        begin
            if (delay == '0)
            begin
                valid_next = 1'b1;
                kind_next  = (req_type == REQ_REPEAT);
                opat_next  = pattern - PAT_W'(1);
                odur_next  = duration;
                last_next  = 1'b1;
            end
            else if (free_found)
            begin
                busy_next[free_idx] = 1'b1;
                cnt_next[free_idx]  = delay;
                pat_next[free_idx]  = pattern - PAT_W'(1);
                dur_next[free_idx]  = duration;
                rep_next[free_idx]  = (req_type == REQ_REPEAT);
            end
        end

        if (cmd.visit)
        begin
            idx_next = status.last_slot ? '0 : idx_reg + IDX_W'(1);
            if (busy_reg[idx_reg])
            begin
                if (cnt_reg[idx_reg] != '0)
                begin
                    cnt_next[idx_reg] = cnt_reg[idx_reg] - DLY_W'(1);
                end
                else
                begin
                    emit_now           = 1'b1;
                    busy_next[idx_reg] = 1'b0;
                    valid_next         = 1'b1;
                    kind_next          = rep_reg[idx_reg];
                    opat_next          = pat_reg[idx_reg];
                    odur_next          = dur_reg[idx_reg];
                    last_next          = !later_zero;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= '0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        pat_reg  <= pat_next;
        dur_reg  <= dur_next;
        rep_reg  <= rep_next;
        kind_reg <= kind_next;
        opat_reg <= opat_next;
        odur_reg <= odur_next;
        last_reg <= last_next;
    end

    assign valid         = valid_reg;
    assign cmd_kind      = kind_reg;
    assign pattern_index = opat_reg;
    assign play_duration = odur_reg;
    assign last          = last_reg;

`ifndef ASSERT_OFF
    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> $past(cmd.visit || cmd.req_load))
        else $error("result strobe without a request or slot visit");

    a_idx_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.visit && status.last_slot) |=> (idx_reg == '0))
        else $error("scan index did not wrap after the last slot");

    a_emit_frees: assert property (@(posedge clk) disable iff (!rst_n)
        emit_now |=> (valid_reg && !busy_reg[$past(idx_reg)]))
        else $error("emitting slot not freed or result not shown");
`endif

endmodule

// File: sim/play_command_checker.sv
// Checker for the delayed command slot scheduler: watches the request and
// command channels, predicts every play command and compares it field by field.
// Depends on dcss_pkg for widths and request codes.
`timescale 1ns / 100ps

module play_command_checker
    import dcss_pkg::*;
#(
    parameter int SLOTS = DEF_SLOTS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic [TYPE_W-1:0]        req_type,
    input  logic [PAT_W-1:0]         pattern,
    input  logic signed [DUR_W-1:0]  duration,
    input  logic [DLY_W-1:0]         delay,
    input  logic                     valid,
    input  logic                     cmd_kind,
    input  logic [PAT_W-1:0]         pattern_index,
    input  logic signed [DUR_W-1:0]  play_duration,
    input  logic                     last,
    output int                       fail_count,
    output int                       pending
);

    localparam int MAX_REPORTS = 40;

    typedef struct {
        logic                    kind;
        logic [PAT_W-1:0]        pat_idx;
        logic signed [DUR_W-1:0] dur;
        logic                    last;
    } play_cmd_t;

    play_cmd_t expected_cmds[$];

    logic                    held_busy      [SLOTS];
    logic [DLY_W-1:0]        held_countdown [SLOTS];
    logic [PAT_W-1:0]        held_pattern   [SLOTS];
    logic signed [DUR_W-1:0] held_duration  [SLOTS];
    logic                    held_repeat    [SLOTS];

    task automatic predict_commands(
        input logic [TYPE_W-1:0]        code,
        input logic [PAT_W-1:0]         pat,
        input logic signed [DUR_W-1:0]  dur,
        input logic [DLY_W-1:0]         dly
    );
        play_cmd_t batch[$];
        play_cmd_t cmd;
        logic      parked;
        parked = 1'b0;
        if (code == REQ_TICK) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (held_busy[i]) begin
                    if (held_countdown[i] != '0) begin
                        held_countdown[i] = held_countdown[i] - DLY_W'(1);
                    end
                    else begin
                        cmd.kind    = held_repeat[i];
                        cmd.pat_idx = held_pattern[i];
                        cmd.dur     = held_duration[i];
                        cmd.last    = 1'b0;
                        batch.push_back(cmd);
                        held_busy[i] = 1'b0;
                    end
                end
            end
        end
        else if ((code == REQ_TIMED || code == REQ_REPEAT) && pat != '0) begin
            if (dly == '0) begin
                cmd.kind    = (code == REQ_REPEAT);
                cmd.pat_idx = pat - PAT_W'(1);
                cmd.dur     = dur;
                cmd.last    = 1'b0;
                batch.push_back(cmd);
            end
            else begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (!parked && !held_busy[i]) begin
                        held_busy[i]      = 1'b1;
                        held_countdown[i] = dly;
                        held_pattern[i]   = pat - PAT_W'(1);
                        held_duration[i]  = dur;
                        held_repeat[i]    = (code == REQ_REPEAT);
                        parked            = 1'b1;
                    end
                end
            end
        end
        if (batch.size() > 0) begin
            batch[batch.size() - 1].last = 1'b1;
        end
        foreach (batch[k]) begin
            expected_cmds.push_back(batch[k]);
        end
    endtask

    task automatic compare_field(
        input string              name,
        input logic signed [31:0] want,
        input logic signed [31:0] got
    );
        if (got !== want) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
                $error("%s: expected %0d, got %0d", name, want, got);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        play_cmd_t want;
        if (!rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                held_busy[i] = 1'b0;
            end
            expected_cmds.delete();
            fail_count = 0;
            pending    = 0;
        end
        else begin
            if (valid) begin
                if (expected_cmds.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $error("unexpected command: kind %0d index %0d duration %0d",
                               cmd_kind, pattern_index, play_duration);
                    end
                end
                else begin
                    want = expected_cmds.pop_front();
                    compare_field("cmd_kind", want.kind, cmd_kind);
                    compare_field("pattern_index", want.pat_idx, pattern_index);
                    compare_field("play_duration", want.dur, play_duration);
                    compare_field("last", want.last, last);
                end
            end
            if (start && !busy) begin
                predict_commands(req_type, pattern, duration, delay);
            end
            pending = expected_cmds.size();
        end
    end

endmodule

// File: sim/tb_delayed_command_slot_scheduler.sv
// Testbench top for the delayed command slot scheduler: drives directed and
// random requests and ticks in bursts, and reports the verdict.
// Depends on dcss_pkg, the scheduler RTL and play_command_checker.
`timescale 1ns / 100ps

module tb_delayed_command_slot_scheduler;
    import dcss_pkg::*;

    localparam int SLOTS          = DEF_SLOTS;
    localparam int RANDOM_ITEMS   = 300;
    localparam int DRAIN_TICKS    = 40;
    localparam logic [TYPE_W-1:0] REQ_UNKNOWN = 2'd3;

    logic                    clk      = 1'b0;
    logic                    rst_n    = 1'b0;
    logic                    start    = 1'b0;
    logic [TYPE_W-1:0]       req_type = REQ_TICK;
    logic [PAT_W-1:0]        pattern  = '0;
    logic signed [DUR_W-1:0] duration = '0;
    logic [DLY_W-1:0]        delay    = '0;

    logic                    busy;
    logic                    valid;
    logic                    cmd_kind;
    logic [PAT_W-1:0]        pattern_index;
    logic signed [DUR_W-1:0] play_duration;
    logic                    last;

    int fail_count;
    int pending;
    int burst_left = 0;

    always #4 clk = ~clk;

    delayed_command_slot_scheduler #(.SLOTS(SLOTS)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .pattern       (pattern),
        .duration      (duration),
        .delay         (delay),
        .valid         (valid),
        .cmd_kind      (cmd_kind),
        .pattern_index (pattern_index),
        .play_duration (play_duration),
        .last          (last)
    );

    play_command_checker #(.SLOTS(SLOTS)) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .pattern       (pattern),
        .duration      (duration),
        .delay         (delay),
        .valid         (valid),
        .cmd_kind      (cmd_kind),
        .pattern_index (pattern_index),
        .play_duration (play_duration),
        .last          (last),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    task automatic transfer_item(
        input logic [TYPE_W-1:0]        code,
        input logic [PAT_W-1:0]         pat,
        input logic signed [DUR_W-1:0]  dur,
        input logic [DLY_W-1:0]         dly
    );
        logic go;
        start    <= 1'b1;
        req_type <= code;
        pattern  <= pat;
        duration <= dur;
        delay    <= dly;
        do
        begin
            @(negedge clk);
            go = !busy;
            @(posedge clk);
        end
        while (!go);
    endtask

    task automatic send(
        input logic [TYPE_W-1:0]        code,
        input logic [PAT_W-1:0]         pat,
        input logic signed [DUR_W-1:0]  dur,
        input logic [DLY_W-1:0]         dly
    );
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap        = $urandom_range(1, 12);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        burst_left--;
        transfer_item(code, pat, dur, dly);
    endtask

    initial begin
        int                      roll;
        logic [TYPE_W-1:0]       code;
        logic [PAT_W-1:0]        pat;
        logic signed [DUR_W-1:0] dur;
        logic [DLY_W-1:0]        dly;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(REQ_TICK, 8'hFF, -16'sd1, 16'hFFFF);
        send(REQ_TIMED, 8'd0, 16'sd100, 16'd0);
        send(REQ_REPEAT, 8'd0, -16'sd100, 16'd5);
        send(REQ_UNKNOWN, 8'h55, 16'sd32767, 16'd0);
        send(REQ_TIMED, 8'd1, -16'sd32768, 16'd0);
        send(REQ_REPEAT, 8'd255, 16'sd32767, 16'd0);
        send(REQ_TIMED, 8'd2, 16'sd0, 16'd1);
        send(REQ_REPEAT, 8'd3, -16'sd1, 16'd1);
        send(REQ_TIMED, 8'd128, 16'sh5555, 16'd1);
        send(REQ_REPEAT, 8'd255, -16'sd32768, 16'd1);
        send(REQ_TIMED, 8'd9, 16'sd9, 16'd2);
        send(REQ_TICK, 8'h00, 16'sd0, 16'd0);
        send(REQ_TICK, 8'hAA, 16'shAAAA, 16'hAAAA);
        send(REQ_TIMED, 8'h80, 16'sh1234, 16'd40);
        send(REQ_REPEAT, 8'd7, -16'sd7, 16'd2);
        send(REQ_TIMED, 8'd6, 16'sd6, 16'd1);
        send(REQ_TICK, 8'h01, 16'sd1, 16'd1);
        send(REQ_TICK, 8'h02, 16'sd2, 16'd2);
        send(REQ_TICK, 8'h03, 16'sd3, 16'd3);
        send(REQ_REPEAT, 8'hAA, 16'sh5555, 16'd0);
        send(REQ_UNKNOWN, 8'd0, 16'sd0, 16'hFFFF);

        // count down the longest delay parked above
        for (int n = 0; n < DRAIN_TICKS; n++) begin
            transfer_item(REQ_TICK, PAT_W'($urandom), DUR_W'($urandom), DLY_W'($urandom));
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            pat  = PAT_W'($urandom_range(1, 255));
            dur  = DUR_W'($urandom);
            dly  = DLY_W'($urandom_range(1, 6));
            code = ($urandom_range(0, 1) == 0) ? REQ_TIMED : REQ_REPEAT;
            if (roll < 40) begin
                code = REQ_TICK;
                pat  = PAT_W'($urandom);
                dly  = DLY_W'($urandom);
            end
            else if (roll < 45) begin
                code = REQ_UNKNOWN;
                pat  = PAT_W'($urandom);
                dly  = DLY_W'($urandom);
            end
            else if (roll < 50) begin
                pat = '0;
                dly = DLY_W'($urandom_range(0, 3));
            end
            else if (roll < 65) begin
                dly = '0;
            end
            else if (roll < 72) begin
                dly = DLY_W'($urandom_range(7, 40));
            end
            send(code, pat, dur, dly);
        end

        start <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (pending != 0);
        repeat (SLOTS + 8) @(posedge clk);

        if (fail_count == 0) begin
            $display("TB_OK");
        end
        else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #12000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/dcss_pkg.sv
hw/rtl/dcss_ctrl.sv
hw/rtl/dcss_datapath.sv
hw/rtl/delayed_command_slot_scheduler.sv
sim/play_command_checker.sv
sim/tb_delayed_command_slot_scheduler.sv
